// ===== design/htp_pkg.sv =====
// ----------------------------------------------------------------------------
// htp_pkg
// Shared types and constants of the homogeneous point transform: port words,
// matrix register file and the classified word between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package htp_pkg;

	localparam int MAG_BITS   = 66;
	localparam int FIFO_DEPTH = 8;
	localparam int NUM_REGS   = 8;
	localparam int REG_BITS   = 64;
	localparam int IDX_BITS   = 4;

	typedef struct packed {
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
	} point_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               w_was_zero;
		logic               saturated;
	} result_t;

	typedef logic [NUM_REGS-1:0][REG_BITS-1:0] matrix_t;

	typedef struct packed {
		logic [2:0][MAG_BITS-1:0] num;
		logic [MAG_BITS-1:0]      den;
		logic [2:0]               neg;
		logic                     w_zero;
	} split_t;

endpackage

`default_nettype wire

// ===== design/htp_front.sv =====
// ----------------------------------------------------------------------------
// htp_front
// Matrix multiply front end: products, column sums, truncation to fixed
// point, then magnitudes and signs of the numerators and of w.
// ----------------------------------------------------------------------------
`default_nettype none

module htp_front import htp_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  point_t  point,
	input  matrix_t matrix,
	output logic    push,
	output split_t  split
);

	localparam int PW  = 2 * WORD_BITS;
	localparam int SPW = 2 * WORD_BITS + 2;

	logic signed [WORD_BITS-1:0] ent [4][4];
	logic signed [WORD_BITS-1:0] pnt [3];
	logic signed [PW-1:0]        prod_s1 [4][3];
	logic signed [SPW-1:0]       sum_s2 [4];
	logic signed [SPW-1:0]       col_s3 [4];
	logic signed [MAG_BITS-1:0]  sx [4];
	logic [MAG_BITS-1:0]         mag [4];
	split_t                      split_s4;
	logic                        v_s1, v_s2, v_s3, v_s4;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				ent[r][c] = matrix[2 * r + (c >> 1)][32 * (c & 1) +: WORD_BITS];
			end
		end
		pnt[0] = point.in_x[WORD_BITS-1:0];
		pnt[1] = point.in_y[WORD_BITS-1:0];
		pnt[2] = point.in_z[WORD_BITS-1:0];
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sx[c]  = MAG_BITS'(col_s3[c]);
			mag[c] = sx[c][MAG_BITS-1] ? MAG_BITS'(-sx[c]) : MAG_BITS'(sx[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[c][r] <= pnt[r] * ent[r][c];
			end
			sum_s2[c] <= SPW'(prod_s1[c][0]) + SPW'(prod_s1[c][1]) + SPW'(prod_s1[c][2]);
			col_s3[c] <= (sum_s2[c] >>> FRAC_BITS) + SPW'(ent[3][c]);
		end
		for (int c = 0; c < 3; c++) begin
			split_s4.num[c] <= mag[c];
			split_s4.neg[c] <= sx[c][MAG_BITS-1] ^ sx[3][MAG_BITS-1];
		end
		split_s4.w_zero <= (col_s3[3] == '0);
		split_s4.den    <= (col_s3[3] == '0) ? (MAG_BITS'(1) << FRAC_BITS) : mag[3];
	end

	assign push  = v_s4;
	assign split = split_s4;

endmodule

`default_nettype wire

// ===== design/htp_fifo.sv =====
// ----------------------------------------------------------------------------
// htp_fifo
// Short queue of classified words between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module htp_fifo import htp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  split_t wdata,
	input  logic   pop,
	output split_t rdata,
	output logic   empty
);

	localparam int PB = $clog2(FIFO_DEPTH);
	localparam int CB = $clog2(FIFO_DEPTH + 1);

	split_t          mem_q [FIFO_DEPTH];
	logic [PB-1:0]   wr_q, rd_q;
	logic [CB-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PB'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PB'(1);
			end
			count_q <= count_q + CB'(push) - CB'(pop);
		end
	end

	assign rdata = mem_q[rd_q];
	assign empty = (count_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CB'(FIFO_DEPTH) |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== design/htp_back.sv =====
// ----------------------------------------------------------------------------
// htp_back
// Perspective divide back end: pipelined restoring divider, one quotient bit
// per stage for all three coordinates, then clamp and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module htp_back import htp_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  split_t  head,
	input  logic    empty,
	output logic    pop,
	output result_t result,
	output logic    result_valid,
	input  logic    result_stall
);

	localparam int QB = WORD_BITS + 1;
	localparam int NS = WORD_BITS + 2;
	localparam int NW = MAG_BITS + FRAC_BITS;
	localparam int LS = NS - 1;
	localparam logic [WORD_BITS-1:0] MIN_V = WORD_BITS'(1) << (WORD_BITS - 1);
	localparam logic [WORD_BITS-1:0] MAX_V = ~MIN_V;
	localparam logic [QB-1:0]        LIM   = QB'(1) << (WORD_BITS - 1);

	logic                en;
	logic [MAG_BITS-1:0] rem_s [NS][3];
	logic [QB-1:0]       low_s [NS][3];
	logic [QB-1:0]       quo_s [NS][3];
	logic [2:0]          ovf_s [NS];
	logic [2:0]          neg_s [NS];
	logic [MAG_BITS-1:0] den_s [NS];
	logic                wz_s  [NS];
	logic                vld_s [NS];

	logic [NW-1:0]               num0 [3];
	logic [NW-1:0]               hi0  [3];
	logic [2:0]                  ovf0;
	logic [QB-1:0]               negq [3];
	logic signed [WORD_BITS-1:0] val  [3];
	logic [2:0]                  sat;
	result_t                     res_q;
	logic                        res_valid_q;

	assign en  = !res_valid_q || !result_stall;
	assign pop = en && !empty;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			num0[l] = NW'(head.num[l]) << FRAC_BITS;
			hi0[l]  = num0[l] >> QB;
			ovf0[l] = hi0[l] >= NW'(head.den);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= ovf0[l] ? '0 : hi0[l][MAG_BITS-1:0];
				low_s[0][l] <= num0[l][QB-1:0];
				quo_s[0][l] <= '0;
			end
			ovf_s[0] <= ovf0;
			neg_s[0] <= head.neg;
			den_s[0] <= head.den;
			wz_s[0]  <= head.w_zero;
		end
	end

	for (genvar k = 1; k < NS; k++) begin : g_step
		logic [MAG_BITS:0] trial [3];
		logic [MAG_BITS:0] diff  [3];
		logic [2:0]        ge;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				trial[l] = {rem_s[k-1][l], low_s[k-1][l][QB-1]};
				diff[l]  = trial[l] - {1'b0, den_s[k-1]};
				ge[l]    = trial[l] >= {1'b0, den_s[k-1]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					rem_s[k][l] <= ge[l] ? diff[l][MAG_BITS-1:0] : trial[l][MAG_BITS-1:0];
					low_s[k][l] <= {low_s[k-1][l][QB-2:0], 1'b0};
					quo_s[k][l] <= {quo_s[k-1][l][QB-2:0], ge[l]};
				end
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
				den_s[k] <= den_s[k-1];
				wz_s[k]  <= wz_s[k-1];
			end
		end
	end

	// clamp to the signed word range
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			negq[l] = QB'(0) - quo_s[LS][l];
			sat[l]  = 1'b0;
			if (ovf_s[LS][l]) begin
				sat[l] = 1'b1;
				val[l] = neg_s[LS][l] ? MIN_V : MAX_V;
			end else if (neg_s[LS][l]) begin
				if (quo_s[LS][l] > LIM) begin
					sat[l] = 1'b1;
					val[l] = MIN_V;
				end else begin
					val[l] = negq[l][WORD_BITS-1:0];
				end
			end else begin
				if (quo_s[LS][l] > LIM - QB'(1)) begin
					sat[l] = 1'b1;
					val[l] = MAX_V;
				end else begin
					val[l] = quo_s[LS][l][WORD_BITS-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= vld_s[LS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.out_x      <= 32'(val[0]);
			res_q.out_y      <= 32'(val[1]);
			res_q.out_z      <= 32'(val[2]);
			res_q.w_was_zero <= wz_s[LS];
			res_q.saturated  <= |sat;
		end
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

endmodule

`default_nettype wire

// ===== design/homogeneous_point_transform.sv =====
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// Transforms Q16.16 points by a 4x4 matrix with perspective divide by w.
//
// Point words arrive on point/point_valid/point_stall and result words leave
// on result/result_valid/result_stall; a word moves when valid is high and
// stall is low. The matrix is loaded through cfg_we/cfg_index/cfg_data while
// the block is idle; writes to index 8 and above are dropped.
// One point is taken per cycle while point_stall is low. The path runs through
// four front stages of multiply, sum, truncate and classify, the queue, a
// divider load stage, then one divider stage per quotient bit and the output
// register.
// A stalled receiver freezes the divider pipeline; the front keeps running
// into an eight-word queue and point_stall rises once the queue and the front
// stages together hold eight words.
// Reset clears the matrix to zero and empties the pipeline and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_point_transform import htp_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                point_valid,
	output logic                point_stall,
	input  point_t              point,
	output logic                result_valid,
	input  logic                result_stall,
	output result_t             result,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [REG_BITS-1:0] cfg_data
);

	localparam int RI = $clog2(NUM_REGS);
	localparam int OB = $clog2(FIFO_DEPTH + 1);

	matrix_t       matrix_q;
	logic [OB-1:0] occ_q;
	logic          accept;
	logic          push;
	logic          pop;
	logic          empty;
	split_t        split;
	split_t        head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q <= '0;
		end else if (cfg_we && cfg_index < IDX_BITS'(NUM_REGS)) begin
			matrix_q[cfg_index[RI-1:0]] <= cfg_data;
		end
	end

	assign point_stall = occ_q >= OB'(FIFO_DEPTH);
	assign accept      = point_valid && !point_stall;

	// words in the front stages plus words in the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OB'(accept) - OB'(pop);
		end
	end

	htp_front #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.point  (point),
		.matrix (matrix_q),
		.push   (push),
		.split  (split)
	);

	htp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (split),
		.pop    (pop),
		.rdata  (head),
		.empty  (empty)
	);

	htp_back #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OB'(FIFO_DEPTH))
		else $error("occupancy above queue depth");

	a_occ_empty: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == '0 |-> empty)
		else $error("queue holds a word not counted");

endmodule

`default_nettype wire

// ===== tb/tb_homogeneous_point_transform.sv =====
// ----------------------------------------------------------------------------
// tb_homogeneous_point_transform
// Self-checking bench for the homogeneous point transform. Points are fed
// through the valid/stall port under a series of matrix settings, loaded
// through the register port while the block is idle. Each result is checked
// field by field against an in-bench model of the transform and divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_homogeneous_point_transform;
	import htp_pkg::*;

	localparam int BAD_IDX   = 8;
	localparam int ONE       = 32'h0001_0000;
	localparam int DRAIN_CYC = 60;
	localparam int WDOG_MAX  = 5000;
	localparam int N_ROWS    = 8;

	typedef struct {
		point_t  p;
		bit      typed;
		result_t r;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                point_valid;
	logic                point_stall;
	point_t              point;
	logic                result_valid;
	logic                result_stall;
	result_t             result;
	logic                cfg_we;
	logic [IDX_BITS-1:0] cfg_index;
	logic [REG_BITS-1:0] cfg_data;

	logic [63:0] mat_copy [NUM_REGS];
	result_t     pending_q [$];
	dir_row_t    dir_tab [N_ROWS];
	int          n_err, n_words_in, n_words_out, idle_cyc, rx_hold;
	bit          tx_busy, rx_busy;

	always #6 clk = ~clk;

	homogeneous_point_transform i_dut (
		.clk, .arst_n, .point_valid, .point_stall, .point,
		.result_valid, .result_stall, .result, .cfg_we, .cfg_index, .cfg_data
	);

	function automatic longint mat_entry(int r, int c);
		logic [63:0] rv;
		rv = mat_copy[r * 2 + c / 2];
		return longint'($signed(rv[(c % 2) * 32 +: 32]));
	endfunction

	// exact column sum floored to the fraction step, plus translation
	function automatic logic signed [79:0] column_sum(longint pc[3], int c);
		logic signed [79:0] acc;
		longint prod;
		acc = '0;
		for (int r = 0; r < 3; r++) begin
			prod = pc[r] * mat_entry(r, c);
			acc = acc + prod;
		end
		return (acc >>> 16) + mat_entry(3, c);
	endfunction

	function automatic result_t transform_point(point_t p);
		longint             pc [3];
		logic signed [79:0] s [3];
		logic signed [79:0] w, v;
		logic [95:0]        n, d, q;
		logic signed [31:0] o [3];
		bit                 neg, sat;
		result_t            r;
		pc[0] = longint'(p.in_x);
		pc[1] = longint'(p.in_y);
		pc[2] = longint'(p.in_z);
		for (int c = 0; c < 3; c++)
			s[c] = column_sum(pc, c);
		w = column_sum(pc, 3);
		sat = 0;
		for (int c = 0; c < 3; c++) begin
			v = s[c];
			if (w == 0) begin
				if (v > 80'sh7fff_ffff) begin
					sat = 1;
					v = 80'sh7fff_ffff;
				end else if (v < -80'sh8000_0000) begin
					sat = 1;
					v = -80'sh8000_0000;
				end
				o[c] = v[31:0];
			end else begin
				neg = (s[c] < 0) != (w < 0);
				n = 96'(s[c] < 0 ? -s[c] : s[c]);
				d = 96'(w < 0 ? -w : w);
				q = (n << 16) / d;
				if (neg) begin
					if (q > 96'h8000_0000) begin
						sat = 1;
						q = 96'h8000_0000;
					end
					o[c] = -q[31:0];
				end else begin
					if (q > 96'h7fff_ffff) begin
						sat = 1;
						q = 96'h7fff_ffff;
					end
					o[c] = q[31:0];
				end
			end
		end
		r.out_x = o[0];
		r.out_y = o[1];
		r.out_z = o[2];
		r.w_was_zero = (w == 0);
		r.saturated = sat;
		return r;
	endfunction

	task automatic load_matrix(logic [31:0] e[4][4]);
		for (int i = 0; i < NUM_REGS; i++) begin
			mat_copy[i] = {e[i / 2][(i % 2) * 2 + 1], e[i / 2][(i % 2) * 2]};
			cfg_we <= 1'b1;
			cfg_index <= IDX_BITS'(i);
			cfg_data <= mat_copy[i];
			@(posedge clk);
		end
		// out of range index must be dropped
		cfg_index <= IDX_BITS'($urandom_range(BAD_IDX, 15));
		cfg_data <= {$urandom, $urandom};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_point(point_t p, result_t exp_r, int gap);
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point <= p;
		point_valid <= 1'b1;
		do @(posedge clk); while (point_stall);
		pending_q.push_back(exp_r);
		n_words_in++;
	endtask

	task automatic drain;
		point_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	function automatic int draw_gap(bit busy);
		return busy ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic logic [31:0] rand_entry(int kind);
		case (kind)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 8 * ONE)) - 4 * ONE);
			2: begin
				case ($urandom_range(0, 6))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0;
					3: return ONE;
					4: return -ONE;
					5: return 32'h1;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return 32'h0;
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return rand_entry(2);
			default: return 32'($signed($urandom_range(0, 400 * ONE)) - 200 * ONE);
		endcase
	endfunction

	// receive side
	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				n_words_out++;
				if (pending_q.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("unexpected result word %h", result);
				end else begin
					e = pending_q.pop_front();
					if (result.out_x !== e.out_x || result.out_y !== e.out_y ||
						result.out_z !== e.out_z || result.w_was_zero !== e.w_was_zero ||
						result.saturated !== e.saturated) begin
						n_err++;
						if (n_err <= 10)
							$display("mismatch: exp %h %h %h %b %b, got %h %h %h %b %b",
								e.out_x, e.out_y, e.out_z, e.w_was_zero, e.saturated,
								result.out_x, result.out_y, result.out_z,
								result.w_was_zero, result.saturated);
					end
				end
				rx_hold = draw_gap(rx_busy);
			end
			if (rx_hold > 0) begin
				result_stall <= 1'b1;
				rx_hold--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no word moved
	always @(posedge clk) begin
		if ((point_valid && !point_stall) || (result_valid && !result_stall))
			idle_cyc = 0;
		else if (++idle_cyc >= WDOG_MAX) begin
			$display("watchdog expired, %0d words outstanding", pending_q.size());
			$display("tb_homogeneous_point_transform: done, errors");
			$finish;
		end
	end

	initial begin
		logic [31:0] m [4][4];
		result_t     zr;
		point_t      p;
		int          kind;
		arst_n = 1'b0;
		point_valid = 1'b0;
		point = '0;
		result_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		n_err = 0;
		n_words_in = 0;
		n_words_out = 0;
		idle_cyc = 0;
		rx_hold = 0;
		tx_busy = 0;
		rx_busy = 0;
		for (int i = 0; i < NUM_REGS; i++)
			mat_copy[i] = '0;
		zr = '{out_x: 0, out_y: 0, out_z: 0, w_was_zero: 1'b1, saturated: 1'b0};
		dir_tab[0] = '{'{0, 0, 0}, 1, zr};
		dir_tab[1] = '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1, zr};
		dir_tab[2] = '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1, zr};
		dir_tab[3] = '{'{ONE, -ONE, ONE}, 1, zr};
		dir_tab[4] = '{'{32'h8000_0000, 32'h7fff_ffff, 32'h1}, 1, zr};
		dir_tab[5] = '{'{32'hffff_ffff, 32'h1, 32'hffff_ffff}, 1, zr};
		dir_tab[6] = '{'{32'h0003_8000, -32'h0002_4000, 32'h0}, 1, zr};
		dir_tab[7] = '{'{32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0002}, 1, zr};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the matrix is zero
		foreach (dir_tab[i])
			send_point(dir_tab[i].p, dir_tab[i].r, 0);
		drain();

		// identity, then perspective w = z with a large gain
		for (int ph = 0; ph < 2; ph++) begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					m[r][c] = (r == c) ? ONE : 32'h0;
			if (ph == 1) begin
				m[2][3] = ONE;
				m[3][3] = 32'h0;
				m[0][0] = 32'h7fff_ffff;
				m[3][1] = 32'h8000_0000;
			end
			load_matrix(m);
			foreach (dir_tab[i])
				send_point(dir_tab[i].p, transform_point(dir_tab[i].p), $urandom_range(0, 3));
			drain();
		end

		for (int ph = 0; ph < 14; ph++) begin
			kind = ph % 4;
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					m[r][c] = rand_entry(kind == 3 ? $urandom_range(0, 2) : kind);
			if (kind == 1 && ph % 8 == 1) begin
				// typical projection: w near one
				m[3][3] = ONE;
				m[0][3] = 32'h0;
				m[1][3] = 32'h0;
				m[2][3] = $urandom_range(0, ONE / 64);
			end
			if (ph == 5 || ph == 13)
				for (int r = 0; r < 4; r++)
					m[r][3] = 32'h0;
			if (ph == 9)
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++)
						m[r][c] = (c % 2) ? 32'h7fff_ffff : 32'h8000_0000;
			load_matrix(m);
			tx_busy = (ph % 3 == 0);
			rx_busy = (ph % 4 == 1);
			for (int i = 0; i < 135; i++) begin
				p.in_x = rand_coord();
				p.in_y = rand_coord();
				p.in_z = rand_coord();
				send_point(p, transform_point(p), draw_gap(tx_busy));
			end
			drain();
		end

		$display("%0d points sent, %0d results checked over 17 matrix settings",
			n_words_in, n_words_out);
		$display("%0d mismatches", n_err);
		if (n_err == 0)
			$display("tb_homogeneous_point_transform: done, clean");
		else
			$display("tb_homogeneous_point_transform: done, errors");
		$finish;
	end

endmodule

// ===== homogeneous_point_transform.f =====
design/htp_pkg.sv
design/htp_front.sv
design/htp_fifo.sv
design/htp_back.sv
design/homogeneous_point_transform.sv
tb/tb_homogeneous_point_transform.sv
